// ===== rtl/core/gha_pkg.sv =====
package gha_pkg;

	// Width of the per-kind byte totals; the totals saturate at all ones.
	localparam int LEN_CNT_W = 36;

	// One GHASH block and one half of it.
	localparam int BLOCK_W = 128;
	localparam int HALF_W = 64;
	localparam int BLOCK_BYTES = BLOCK_W / 8;

	// Width of a byte count on the stream and of the mode code.
	localparam int COUNT_W = 5;
	localparam int MODE_W = 2;

	// GCM reduction polynomial in reflected order: 0xE1 followed by 120 zero bits.
	localparam logic [BLOCK_W-1:0] REDUCE_POLY = {8'he1, {(BLOCK_W - 8){1'b0}}};

	// Kind of an input beat.
	typedef enum logic [MODE_W-1:0] {
		MODE_AAD    = 2'd0,
		MODE_CIPHER = 2'd1,
		MODE_FINISH = 2'd2
	} mode_t;

	// A data block after padding, with its clamped byte count.
	typedef struct packed {
		logic [BLOCK_W-1:0] block;
		logic [COUNT_W-1:0] count;
		logic               active;
	} pad_res_t;

endpackage

// ===== rtl/core/gha_pad.sv =====
module gha_pad
	import gha_pkg::*;
(
	input  logic [BLOCK_W-1:0] block,
	input  logic [COUNT_W-1:0] count,
	output pad_res_t           res
);

	logic [COUNT_W-1:0] count_eff;
	logic [BLOCK_W-1:0] masked;

	// Counts above a full block are taken as a full block.
	assign count_eff = (count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : count;

	// Clear every byte at or past the count; byte 0 sits in the top bits.
	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (COUNT_W'(i) < count_eff) begin
				masked[BLOCK_W - 1 - 8 * i -: 8] = block[BLOCK_W - 1 - 8 * i -: 8];
			end else begin
				masked[BLOCK_W - 1 - 8 * i -: 8] = 8'h00;
			end
		end
	end

	assign res.block  = masked;
	assign res.count  = count_eff;
	assign res.active = (count != '0);

endmodule

// ===== rtl/core/gha_gfmul.sv =====
module gha_gfmul
	import gha_pkg::*;
(
	input  logic [BLOCK_W-1:0] x,
	input  logic [BLOCK_W-1:0] h,
	output logic [BLOCK_W-1:0] z
);

	// Bit-reflected GF(2^128) product. The shifted multiples of H depend only
	// on the key, so the data path is an AND plane followed by an XOR tree.
	always_comb begin
		logic [BLOCK_W-1:0] v;
		logic [BLOCK_W-1:0] p;
		v = h;
		p = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			if (x[BLOCK_W - 1 - i]) begin
				p = p ^ v;
			end
			v = v[0] ? ((v >> 1) ^ REDUCE_POLY) : (v >> 1);
		end
		z = p;
	end

endmodule

// ===== rtl/core/ghash_accumulator_unit.sv =====
// GCM GHASH accumulator. Load the hash subkey H through the configuration port
// (index 0 is bytes 0 to 7, index 1 is bytes 8 to 15, byte 0 most significant).
// Each data beat carries one 128-bit block with tuser selecting additional data
// (0) or ciphertext (1); bytes past byte_count are zeroed before the block is
// folded in, and byte totals are kept per kind, saturating. A finish beat
// (tuser 2) folds in the 64-bit bit lengths, emits the hash on the master side
// and clears the accumulator and totals; mode 3 and data beats with a byte
// count of zero are dropped. One beat is taken every clock but for the stall
// below: each beat passes an input register, then a combinational GF(2^128)
// multiply, and the hash is held in the result register for the master. The
// one result register is the only source of stall: a finish beat waits while a
// previous hash is still unread, and the beats behind it wait with it;
// otherwise data beats never stall.
module ghash_accumulator_unit
	import gha_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [HALF_W-1:0]   cfg_data,
	// Slave side.
	input  logic                s_tvalid,
	output logic                s_tready,
	// tdata: block_high [63:0], block_low [127:64], byte_count [132:128], zero [135:133]
	input  logic [135:0]        s_tdata,
	// tuser: mode [1:0]
	input  logic [MODE_W-1:0]   s_tuser,
	// Master side.
	output logic                m_tvalid,
	input  logic                m_tready,
	// tdata: hash_high [63:0], hash_low [127:64]
	output logic [BLOCK_W-1:0]  m_tdata
);

	localparam logic [LEN_CNT_W-1:0] LEN_MAX = '1;

	logic [HALF_W-1:0]    key_high_q;
	logic [HALF_W-1:0]    key_low_q;

	logic                 valid_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [BLOCK_W-1:0]   block_s1;
	logic [COUNT_W-1:0]   count_s1;

	logic [BLOCK_W-1:0]   acc_q;
	logic [LEN_CNT_W-1:0] aad_total_q;
	logic [LEN_CNT_W-1:0] cipher_total_q;

	logic                 out_valid_q;
	logic [BLOCK_W-1:0]   out_data_q;

	pad_res_t             pad;
	logic                 is_finish;
	logic                 is_data;
	logic                 fire_s1;
	logic [BLOCK_W-1:0]   len_block;
	logic [BLOCK_W-1:0]   mul_in;
	logic [BLOCK_W-1:0]   mul_out;
	logic [LEN_CNT_W:0]   aad_sum;
	logic [LEN_CNT_W:0]   cipher_sum;

	// Hash subkey registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index) begin
				key_low_q <= cfg_data;
			end else begin
				key_high_q <= cfg_data;
			end
		end
	end

	// Input register; a beat moves in whenever the stage empties this cycle.
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= s_tuser;
			block_s1 <= {s_tdata[63:0], s_tdata[127:64]};
			count_s1 <= s_tdata[132:128];
		end
	end

	// Pad the block and decode the beat kind.
	gha_pad u_pad (
		.block (block_s1),
		.count (count_s1),
		.res   (pad)
	);

	assign is_finish = (mode_s1 == MODE_FINISH);
	assign is_data   = ((mode_s1 == MODE_AAD) || (mode_s1 == MODE_CIPHER)) && pad.active;

	// A finish beat may only leave when the result register is free.
	assign fire_s1 = valid_s1 && (!is_finish || !out_valid_q || m_tready);

	// Length block: 64-bit bit counts of additional data then ciphertext.
	assign len_block = {HALF_W'(aad_total_q) << 3, HALF_W'(cipher_total_q) << 3};

	assign mul_in = acc_q ^ (is_finish ? len_block : pad.block);

	gha_gfmul u_gfmul (
		.x (mul_in),
		.h ({key_high_q, key_low_q}),
		.z (mul_out)
	);

	// Saturating byte totals.
	assign aad_sum    = {1'b0, aad_total_q} + (LEN_CNT_W + 1)'(pad.count);
	assign cipher_sum = {1'b0, cipher_total_q} + (LEN_CNT_W + 1)'(pad.count);

	// Accumulator and byte totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			aad_total_q    <= '0;
			cipher_total_q <= '0;
		end else if (fire_s1) begin
			if (is_finish) begin
				acc_q          <= '0;
				aad_total_q    <= '0;
				cipher_total_q <= '0;
			end else if (is_data) begin
				acc_q <= mul_out;
				if (mode_s1 == MODE_AAD) begin
					aad_total_q <= aad_sum[LEN_CNT_W] ? LEN_MAX : aad_sum[LEN_CNT_W-1:0];
				end else begin
					cipher_total_q <= cipher_sum[LEN_CNT_W] ?
						LEN_MAX : cipher_sum[LEN_CNT_W-1:0];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_finish) begin
			out_data_q <= mul_out;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_data_q[HALF_W-1:0], out_data_q[BLOCK_W-1:HALF_W]};

endmodule
